// ===== rtl/bdar_pkg.sv =====
// ----------------------------------------------------------------------------
// bdar_pkg
// shared types and constants for the button debounce and auto-repeat block
// ----------------------------------------------------------------------------
`default_nettype none

package bdar_pkg;

    localparam int NUM_BUTTONS_DEF = 3;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int FIELD_W   = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 1'b1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd3;

    typedef struct packed {
        logic pressed;
        logic long_press;
        logic response;
    } t_lane_stat;

endpackage

`default_nettype wire

// ===== rtl/bdar_if.sv =====
// ----------------------------------------------------------------------------
// bdar_if
// valid/ready channels carrying sample words in and status words out
// ----------------------------------------------------------------------------
`default_nettype none

interface bdar_in_if
    import bdar_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               sample_now;
    logic [FIELD_W-1:0] raw_levels;
    logic [FIELD_W-1:0] clear_response;

    modport source (output valid, output sample_now, output raw_levels,
                    output clear_response, input ready);
    modport sink   (input valid, input sample_now, input raw_levels,
                    input clear_response, output ready);
endinterface

interface bdar_out_if
    import bdar_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] pressed_mask;
    logic [FIELD_W-1:0] long_press_mask;
    logic [FIELD_W-1:0] response_mask;

    modport source (output valid, output pressed_mask, output long_press_mask,
                    output response_mask, input ready);
    modport sink   (input valid, input pressed_mask, input long_press_mask,
                    input response_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdar_lane.sv =====
// ----------------------------------------------------------------------------
// bdar_lane
// one button: three-sample debounce, hold countdown and response flag
// ----------------------------------------------------------------------------
`default_nettype none

module bdar_lane
    import bdar_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic                   i_sample,
    input  wire logic                   i_level,
    input  wire logic                   i_clear,
    input  wire logic [COUNT_WIDTH-1:0] i_long_ticks,
    input  wire logic [COUNT_WIDTH-1:0] i_repeat_ticks,
    output t_lane_stat                  o_stat
);

    logic [1:0]             r_hist,  n_hist;
    logic                   r_deb,   n_deb;
    logic [COUNT_WIDTH-1:0] r_cnt,   n_cnt;
    logic                   r_long,  n_long;
    logic                   r_resp,  n_resp;
    logic                   w_stable;

    assign w_stable = (i_level == r_hist[0]) && (i_level == r_hist[1]);

    always_comb begin
        n_hist = r_hist;
        n_deb  = r_deb;
        n_cnt  = r_cnt;
        n_long = r_long;
        n_resp = r_resp & ~i_clear;
        if (i_sample) begin
            n_hist = {r_hist[0], i_level};
            if (w_stable) begin
                if (r_deb != i_level) begin
                    n_deb = i_level;
                    if (!i_level) begin
                        n_cnt  = i_long_ticks;
                        n_resp = 1'b1;
                    end else begin
                        n_cnt  = '0;
                        n_long = 1'b0;
                    end
                end else if (!i_level) begin
                    // fires when the count is one or zero
                    if (r_cnt[COUNT_WIDTH-1:1] == '0) begin
                        n_long = 1'b1;
                        n_resp = 1'b1;
                        n_cnt  = i_repeat_ticks;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= 2'b00;
            r_deb  <= 1'b1;
            r_cnt  <= '0;
            r_long <= 1'b0;
            r_resp <= 1'b0;
        end else if (i_accept) begin
            r_hist <= n_hist;
            r_deb  <= n_deb;
            r_cnt  <= n_cnt;
            r_long <= n_long;
            r_resp <= n_resp;
        end
    end

    assign o_stat.pressed    = ~n_deb;
    assign o_stat.long_press = n_long;
    assign o_stat.response   = n_resp;

endmodule

`default_nettype wire

// ===== rtl/bdar_merge.sv =====
// ----------------------------------------------------------------------------
// bdar_merge
// gathers lane status into masks and holds them in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module bdar_merge
    import bdar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_lane_stat i_stat [NUM_BUTTONS],
    output logic           o_in_ready,
    bdar_out_if.source     o_out
);

    logic [FIELD_W-1:0] w_pm, w_lm, w_rm;
    logic [FIELD_W-1:0] r_pm, r_lm, r_rm;
    logic               r_valid, n_valid;

    for (genvar i = 0; i < FIELD_W; i++) begin : g_bit
        if (i < NUM_BUTTONS) begin : g_lane
            assign w_pm[i] = i_stat[i].pressed;
            assign w_lm[i] = i_stat[i].long_press;
            assign w_rm[i] = i_stat[i].response;
        end else begin : g_none
            assign w_pm[i] = 1'b0;
            assign w_lm[i] = 1'b0;
            assign w_rm[i] = 1'b0;
        end
    end

    assign o_in_ready = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pm <= w_pm;
            r_lm <= w_lm;
            r_rm <= w_rm;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.pressed_mask    = r_pm;
    assign o_out.long_press_mask = r_lm;
    assign o_out.response_mask   = r_rm;

endmodule

`default_nettype wire

// ===== rtl/button_debounce_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// button_debounce_auto_repeat
// debounced active-low buttons with long-press auto-repeat, one lane each
//
//  port          dir   handshake       word
//  i_in          in    valid/ready     sample_now, raw_levels, clear_response
//  o_out         out   valid/ready     pressed_mask, long_press_mask,
//                                      response_mask
//  i_cfg_*       in    write enable    register index, 16-bit data
//
//  one word per clock while i_in.ready is high; every lane updates in the
//  accept cycle and the merged masks appear in the output register on the
//  next cycle, through the single output register
//  i_in.ready is low only while the output register is full and not taken
//  synchronous active-low reset: history zero, levels released, counts zero
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_auto_repeat
    import bdar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bdar_in_if.sink                   i_in,
    bdar_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [CFG_W-1:0]       r_long_ticks;
    logic [CFG_W-1:0]       r_repeat_ticks;
    logic [COUNT_WIDTH-1:0] w_long_ticks;
    logic [COUNT_WIDTH-1:0] w_repeat_ticks;
    logic                   w_ready;
    logic                   w_accept;
    t_lane_stat             w_stat [NUM_BUTTONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= LONG_PRESS_RST;
            r_repeat_ticks <= REPEAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LONG_PRESS: r_long_ticks   <= i_cfg_wdata;
                CFG_REPEAT:     r_repeat_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_long_ticks   = COUNT_WIDTH'(r_long_ticks);
    assign w_repeat_ticks = COUNT_WIDTH'(r_repeat_ticks);

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic w_level;
        logic w_clear;

        if (b < FIELD_W) begin : g_pin
            assign w_level = i_in.raw_levels[b];
            assign w_clear = i_in.clear_response[b];
        end else begin : g_nopin
            assign w_level = 1'b0;
            assign w_clear = 1'b0;
        end

        bdar_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_accept       (w_accept),
            .i_sample       (i_in.sample_now),
            .i_level        (w_level),
            .i_clear        (w_clear),
            .i_long_ticks   (w_long_ticks),
            .i_repeat_ticks (w_repeat_ticks),
            .o_stat         (w_stat[b])
        );
    end

    bdar_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_stat     (w_stat),
        .o_in_ready (w_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
